// ----- hdl/svm_pkg.sv -----
// Shared types and constants of the sample voice mixer.
`default_nettype none

package svm_pkg;

  // Input item mode codes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_TRIG   = 2'd1;
  localparam logic [1:0] MODE_RENDER = 2'd2;

  // Command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PW    = 1;
  localparam int CMD_CW    = 2;

  // Voice gain: multiply by 12, shift right by 8
  localparam int GAIN_SHIFT = 8;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_TRIG,
    CMD_RENDER
  } cmd_e;

  typedef struct packed {
    cmd_e        op;
    logic [15:0] addr;      // load address or start address
    logic [15:0] data;      // load word or mix sample
    logic [16:0] end_addr;
    logic [23:0] step;
  } cmd_t;

  typedef struct packed {
    logic [15:0] mixed;
    logic [3:0]  active;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN,
    BK_FIN
  } back_state_e;

endpackage

`default_nettype wire

// ----- hdl/sample_voice_mixer_unit.sv -----
// Top level of the sample voice mixer: front, back and result register.
//
//  Channel  | Handshake    | Payload
//  ---------+--------------+-------------------------------------------------
//  request  | push_i/full_o| mode, load_address, load_data, start_address,
//           |              | end_address, step_in, mix_in
//  result   | pop_i/empty_o| mixed_sample, voices_active (render only)
//
// A load or trigger request is handled in the back end's idle state once it leaves the
// two-entry command queue. A render request walks the voices one voice per cycle through
// the single read port of the sample memory, then passes through pipeline drain and
// result hand-off. Reset leaves all voices idle; sample
// memory content is undefined until loaded. A result waiting in the output
// register stalls the back end only at its next render hand-off.
`default_nettype none

module sample_voice_mixer_unit #(
  parameter int VOICES           = 8,
  parameter int SAMPLE_ADDR_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic [15:0]        load_address_i,
  input  wire logic signed [15:0] load_data_i,
  input  wire logic [15:0]        start_address_i,
  input  wire logic [16:0]        end_address_i,
  input  wire logic [23:0]        step_in_i,
  input  wire logic signed [15:0] mix_in_i,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output logic signed [15:0]      mixed_sample_o,
  output logic [3:0]              voices_active_o
);

  svm_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;
  svm_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid_q;
  svm_pkg::res_t out_q;

  svm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push_i),
    .full_o          (full_o),
    .mode_i          (mode_i),
    .load_address_i  (load_address_i),
    .load_data_i     (load_data_i),
    .start_address_i (start_address_i),
    .end_address_i   (end_address_i),
    .step_in_i       (step_in_i),
    .mix_in_i        (mix_in_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  svm_back #(
    .VOICES           (VOICES),
    .SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign res_ready       = !out_valid_q || pop_i;
  assign empty_o         = !out_valid_q;
  assign mixed_sample_o  = out_q.mixed;
  assign voices_active_o = out_q.active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/svm_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/svm_front.sv -----
// Front end: accepts input items, classifies them and queues commands.
`default_nettype none

module svm_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic [15:0]        load_address_i,
  input  wire logic signed [15:0] load_data_i,
  input  wire logic [15:0]        start_address_i,
  input  wire logic [16:0]        end_address_i,
  input  wire logic [23:0]        step_in_i,
  input  wire logic signed [15:0] mix_in_i,
  output logic                    cmd_valid_o,
  output svm_pkg::cmd_t           cmd_o,
  input  wire logic               cmd_pop_i
);

  svm_pkg::cmd_t                 queue_q [svm_pkg::CMD_DEPTH];
  logic [svm_pkg::CMD_PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [svm_pkg::CMD_CW-1:0]    count_q, count_d;
  svm_pkg::cmd_t                 cmd_new;
  logic                          keep;
  logic                          wr_en;
  logic                          rd_en;

  always_comb begin
    cmd_new          = '0;
    cmd_new.end_addr = end_address_i;
    cmd_new.step     = step_in_i;
    keep             = 1'b1;
    unique case (mode_i)
      svm_pkg::MODE_LOAD: begin
        cmd_new.op   = svm_pkg::CMD_LOAD;
        cmd_new.addr = load_address_i;
        cmd_new.data = load_data_i;
      end
      svm_pkg::MODE_TRIG: begin
        cmd_new.op   = svm_pkg::CMD_TRIG;
        cmd_new.addr = start_address_i;
      end
      svm_pkg::MODE_RENDER: begin
        cmd_new.op   = svm_pkg::CMD_RENDER;
        cmd_new.data = mix_in_i;
      end
      default: begin
        // unused mode: drop the request
        cmd_new.op = svm_pkg::CMD_LOAD;
        keep       = 1'b0;
      end
    endcase
  end

  assign full_o      = (count_q == svm_pkg::CMD_CW'(svm_pkg::CMD_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rptr_q];
  assign wr_en       = push_i && !full_o && keep;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wptr_d  = wr_en ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = rd_en ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    priority if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_q[wptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/svm_back.sv -----
// Back end: sample memory, voice state and the per-sample voice walk.
`default_nettype none

module svm_back #(
  parameter int VOICES           = 8,
  parameter int SAMPLE_ADDR_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_valid_i,
  input  svm_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          res_valid_o,
  output svm_pkg::res_t res_o,
  input  wire logic     res_ready_i
);

  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);
  localparam int AW = SAMPLE_ADDR_BITS;

  svm_pkg::back_state_e state_q, state_d;

  logic [32:0]   pos_q  [VOICES];
  logic [23:0]   step_q [VOICES];
  logic [16:0]   end_q  [VOICES];
  logic [CW-1:0] active_q;
  logic [IW-1:0] idx_q;
  logic [15:0]   acc_q;
  logic          play_q;

  logic [32:0]        cur_pos;
  logic [16:0]        cur_p;
  logic               cur_live;
  logic               cur_play;
  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic [15:0]        rdata;
  logic signed [19:0] prod;
  logic [15:0]        scaled;
  logic [15:0]        acc_sum;
  logic               is_last;

  // control decoded from state
  logic ram_we;
  logic trig_en;
  logic start_render;
  logic run_en;
  logic acc_en;

  assign cur_pos  = pos_q[idx_q];
  assign cur_p    = cur_pos[32:16];
  assign cur_live = (step_q[idx_q] != '0);
  assign cur_play = cur_live && (cur_p < end_q[idx_q]);
  assign is_last  = (idx_q == IW'(VOICES - 1));

  // lowest-numbered idle voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (step_q[v] == '0) begin
        free_found = 1'b1;
        free_idx   = IW'(v);
      end
    end
  end

  svm_ram #(
    .WIDTH (16),
    .DEPTH (2 ** SAMPLE_ADDR_BITS)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(cmd_i.addr)),
    .wdata_i (cmd_i.data),
    .re_i    (run_en),
    .raddr_i (AW'(cur_p)),
    .rdata_o (rdata)
  );

  // sample * 12 as (s << 3) + (s << 2), then floor shift by 8
  always_comb begin
    prod    = (20'(signed'(rdata)) <<< 3) + (20'(signed'(rdata)) <<< 2);
    scaled  = {{4{prod[19]}}, prod[19:svm_pkg::GAIN_SHIFT]};
    acc_sum = play_q ? acc_q + scaled : acc_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      svm_pkg::BK_IDLE: begin
        if (cmd_valid_i && cmd_i.op == svm_pkg::CMD_RENDER) begin
          state_d = svm_pkg::BK_RUN;
        end
      end
      svm_pkg::BK_RUN: begin
        if (is_last) begin
          state_d = svm_pkg::BK_DRAIN;
        end
      end
      svm_pkg::BK_DRAIN: begin
        state_d = svm_pkg::BK_FIN;
      end
      svm_pkg::BK_FIN: begin
        if (res_ready_i) begin
          state_d = svm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = svm_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop_o    = (state_q == svm_pkg::BK_IDLE) && cmd_valid_i;
    ram_we       = cmd_pop_o && (cmd_i.op == svm_pkg::CMD_LOAD);
    trig_en      = cmd_pop_o && (cmd_i.op == svm_pkg::CMD_TRIG) && free_found;
    start_render = cmd_pop_o && (cmd_i.op == svm_pkg::CMD_RENDER);
    run_en       = (state_q == svm_pkg::BK_RUN);
    acc_en       = run_en || (state_q == svm_pkg::BK_DRAIN);
    res_valid_o  = (state_q == svm_pkg::BK_FIN);
    res_o.mixed  = acc_q;
    res_o.active = 4'(active_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= svm_pkg::BK_IDLE;
      active_q <= '0;
      idx_q    <= '0;
      play_q   <= 1'b0;
      for (int v = 0; v < VOICES; v++) begin
        pos_q[v]  <= '0;
        step_q[v] <= '0;
        end_q[v]  <= '0;
      end
    end else begin
      state_q <= state_d;
      play_q  <= run_en && cur_play;
      if (start_render) begin
        idx_q <= '0;
      end else if (run_en) begin
        idx_q <= idx_q + 1'b1;
      end
      if (trig_en) begin
        pos_q[free_idx]  <= {1'b0, cmd_i.addr, 16'h0000};
        end_q[free_idx]  <= cmd_i.end_addr;
        step_q[free_idx] <= cmd_i.step;
        if (cmd_i.step != '0) begin
          active_q <= active_q + 1'b1;
        end
      end
      if (run_en) begin
        if (cur_play) begin
          // advance position, wrapping at 33 bits
          pos_q[idx_q] <= cur_pos + {9'b0, step_q[idx_q]};
        end else if (cur_live) begin
          // end reached: drop the voice
          step_q[idx_q] <= '0;
          active_q      <= active_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_render) begin
      acc_q <= cmd_i.data;
    end else if (acc_en) begin
      acc_q <= acc_sum;
    end
  end

endmodule

`default_nettype wire
